// File: src/mbrf_pkg.sv
// ----------------------------------------------------------------------------
// Modbus RTU request framer package
// Command codes, function codes, frame sizes and the byte-wide CRC step.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrf_pkg;

    typedef logic [1:0] t_op;
    typedef logic [7:0] t_byte;
    typedef logic [15:0] t_crc;
    typedef logic [3:0] t_pos;

    localparam t_op OP_WRITE_COIL = 2'd0;
    localparam t_op OP_WRITE_REGS = 2'd1;
    localparam t_op OP_READ_INPUT = 2'd2;
    localparam t_op OP_UNUSED = 2'd3;

    localparam t_byte FC_WRITE_COIL = 8'h05;
    localparam t_byte FC_WRITE_REGS = 8'h10;
    localparam t_byte FC_READ_INPUT = 8'h04;
    localparam t_byte BYTE_ZERO = 8'h00;
    localparam t_byte BYTE_ONES = 8'hFF;
    localparam t_byte REG_COUNT = 8'h02;
    localparam t_byte BYTE_COUNT = 8'h04;

    localparam t_crc CRC_INIT = 16'hFFFF;
    localparam t_crc CRC_POLY = 16'hA001;

    localparam t_byte SLAVE_RESET = 8'h01;

    // bytes before the CRC: short frames (coil write, read) and the register write
    localparam t_pos DATA_LEN_SHORT = 4'd6;
    localparam t_pos DATA_LEN_LONG = 4'd11;

    // one byte through the reflected CRC-16, a bit per step
    function automatic t_crc crc_update(input t_crc crc_in, input t_byte data);
        t_crc c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: src/modbus_rtu_request_framer_top.sv
// ----------------------------------------------------------------------------
// Modbus RTU request framer
// Turns one command into a Modbus RTU request frame, one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one command per transaction: tuser carries the op code,
//   tdata the register address and the 32-bit payload. Master side emits the
//   frame bytes in transmit order on tdata[7:0]; tlast marks the CRC high
//   byte. The slave address comes from the configuration register; the user
//   must write it with i_cfg_wr_en / i_cfg_wr_data only while the block is
//   idle; the block itself leaves this to the user.
// Byte flow:
//   A taken command is held in the command registers, then its first byte
//   is loaded into the output register. Within a frame, unless the receiver
//   stalls, one byte a cycle enters the output register, data bytes via
//   the shared byte-wide CRC unit. A frame is 8 bytes (coil write, read)
//   or 13 (register write); the next command is taken as its last byte loads.
// Reset:
//   Synchronous, active low. Clears the sequencer and the output valid and
//   sets the slave address to 1.
// Stall:
//   While the receiver holds tready low the output byte holds and the
//   sequencer waits; an unused op code 3 is taken and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_request_framer_top (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // configuration: slave address
    input  wire                  i_cfg_wr_en,
    input  wire  [7:0]           i_cfg_wr_data,
    // command stream
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire  [47:0]          s_axis_tdata,  // [15:0] register_address, [47:16] payload
    input  wire  mbrf_pkg::t_op  s_axis_tuser,  // [1:0] op
    // frame byte stream
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [7:0]           m_axis_tdata,  // [7:0] frame_byte
    output logic                 m_axis_tlast   // last_byte
);
    import mbrf_pkg::*;

    // held command and sequencer
    logic          r_busy, n_busy;
    t_pos          r_pos, n_pos;
    t_op           r_op, n_op;
    logic [15:0]   r_addr, n_addr;
    logic [31:0]   r_pay, n_pay;
    t_crc          r_crc, n_crc;
    t_byte         r_slave;

    // output register
    logic          r_out_valid, n_out_valid;
    t_byte         r_out_data, n_out_data;
    logic          r_out_last, n_out_last;

    logic          w_can_load;
    logic          w_load;
    logic          w_load_last;
    logic          w_in_accept;
    t_pos          w_data_len;
    t_byte         w_data_byte;

    assign w_can_load = !r_out_valid || m_axis_tready;
    assign w_load = r_busy && w_can_load;
    assign w_data_len = (r_op == OP_WRITE_REGS) ? DATA_LEN_LONG : DATA_LEN_SHORT;
    assign w_load_last = w_load && (r_pos == w_data_len + 4'd1);

    // take a command while idle, or as the current frame's last byte is loaded
    assign s_axis_tready = !r_busy || w_load_last;
    assign w_in_accept = s_axis_tvalid && s_axis_tready;

    // frame byte at the current position (header and data part)
    always_comb begin
        w_data_byte = BYTE_ZERO;
        case (r_pos)
            4'd0: w_data_byte = r_slave;
            4'd1: begin
                case (r_op)
                    OP_WRITE_COIL: w_data_byte = FC_WRITE_COIL;
                    OP_WRITE_REGS: w_data_byte = FC_WRITE_REGS;
                    default:       w_data_byte = FC_READ_INPUT;
                endcase
            end
            4'd2: w_data_byte = r_addr[15:8];
            4'd3: w_data_byte = r_addr[7:0];
            4'd4: begin
                if (r_op == OP_WRITE_COIL) begin
                    w_data_byte = r_pay[0] ? BYTE_ONES : BYTE_ZERO;
                end else begin
                    w_data_byte = BYTE_ZERO;
                end
            end
            4'd5: w_data_byte = (r_op == OP_WRITE_COIL) ? BYTE_ZERO : REG_COUNT;
            4'd6: w_data_byte = BYTE_COUNT;
            4'd7: w_data_byte = r_pay[15:8];
            4'd8: w_data_byte = r_pay[7:0];
            4'd9: w_data_byte = r_pay[31:24];
            4'd10: w_data_byte = r_pay[23:16];
            default: w_data_byte = BYTE_ZERO;
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_pos = r_pos;
        n_op = r_op;
        n_addr = r_addr;
        n_pay = r_pay;
        n_crc = r_crc;
        n_out_valid = r_out_valid;
        n_out_data = r_out_data;
        n_out_last = r_out_last;

        // drop the output byte once taken
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        // advance the frame: data bytes feed the CRC, then CRC low and high
        if (w_load) begin
            n_out_valid = 1'b1;
            n_pos = r_pos + 4'd1;
            if (r_pos < w_data_len) begin
                n_out_data = w_data_byte;
                n_out_last = 1'b0;
                n_crc = crc_update(r_crc, w_data_byte);
            end else if (r_pos == w_data_len) begin
                n_out_data = r_crc[7:0];
                n_out_last = 1'b0;
            end else begin
                n_out_data = r_crc[15:8];
                n_out_last = 1'b1;
                n_busy = 1'b0;
            end
        end

        // hold a new command; op code 3 is taken and dropped
        if (w_in_accept && (s_axis_tuser != OP_UNUSED)) begin
            n_busy = 1'b1;
            n_pos = '0;
            n_op = s_axis_tuser;
            n_addr = s_axis_tdata[15:0];
            n_pay = s_axis_tdata[47:16];
            n_crc = CRC_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos <= '0;
            r_crc <= CRC_INIT;
            r_out_valid <= 1'b0;
            r_out_last <= 1'b0;
            r_slave <= SLAVE_RESET;
        end else begin
            r_busy <= n_busy;
            r_pos <= n_pos;
            r_crc <= n_crc;
            r_out_valid <= n_out_valid;
            r_out_last <= n_out_last;
            if (i_cfg_wr_en) begin
                r_slave <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        r_addr <= n_addr;
        r_pay <= n_pay;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = r_out_data;
    assign m_axis_tlast = r_out_last;

endmodule

`default_nettype wire

// File: src/mbrf_checker.sv
// ----------------------------------------------------------------------------
// Modbus RTU request framer checker
// Port-level assertions on the framer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrf_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    input  wire  [1:0]  s_axis_tuser,
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire  [7:0]  m_axis_tdata,
    input  wire         m_axis_tlast
);
    import mbrf_pkg::*;

    // a stalled byte holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output byte changed while stalled");

    // a frame in progress blocks new commands while its byte is stalled
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
        else $error("command taken in the middle of a frame");

    // an accepted command (not op 3) puts a frame byte on offer after the command and output registers
    a_cmd_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_UNUSED) |=>
            ##1 m_axis_tvalid)
        else $error("command produced no frame byte");

    // within a frame the next byte follows the taken one at once
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("gap inside a frame");

endmodule

bind modbus_rtu_request_framer_top mbrf_checker u_mbrf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: verif/tb_modbus_rtu_request_framer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU request framer testbench
// Sends command transactions and checks every frame byte. The bench predicts
// each byte from its own copy of the slave address and its own bit-serial
// CRC-16. Directed frames come first, then slave address changes, a long
// receiver hold-off, and random commands. Both stream sides idle at random.
// ----------------------------------------------------------------------------

module tb_modbus_rtu_request_framer_top;

    import mbrf_pkg::*;

    localparam int CLK_HALF = 10;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_COMMANDS = 160;
    // longest frame plus output register, with margin
    localparam int SETTLE_CYCLES = 20;
    localparam int RUN_LIMIT_NS = 4_000_000;

    typedef struct packed {
        t_byte data;
        logic  last;
    } frame_byte_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [7:0]  i_cfg_wr_data = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // [15:0] register_address, [47:16] payload
    t_op         s_axis_tuser = OP_WRITE_COIL;  // [1:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [7:0] frame_byte
    logic        m_axis_tlast;        // last_byte

    // predicted frame bytes, oldest first
    frame_byte_t pending_frame_bytes[$];
    // slave address the block should hold right now
    t_byte       slave_addr_shadow = SLAVE_RESET;
    int          mismatch_count = 0;

    // sender burst state
    int          burst_left = 0;
    bit          sender_gaps_on = 1'b1;

    // long hold-off request: the test bumps hold_req_id, the receiver serves it
    int          hold_req_id = 0;
    int          hold_ack_id = 0;
    int          hold_len_req = 0;
    int          hold_cnt = 0;
    int unsigned stall_phase = 0;
    int          stall_mode = 0;

    modbus_rtu_request_framer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Bit-serial reflected CRC-16: shift one data bit at a time, LSB first.
    function automatic t_crc crc16_shift_byte(input t_crc acc, input t_byte b);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb = acc[0] ^ b[i];
            acc = acc >> 1;
            if (fb) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    // Build the request frame for one accepted command and queue its bytes.
    // Op code 3 is dropped by the block and yields nothing.
    task automatic predict_request_frame(input t_op op, input logic [15:0] addr,
                                         input logic [31:0] pay);
        t_byte body[$];
        t_crc  crc;
        frame_byte_t fb;
        begin
            if (op == OP_UNUSED) begin
                return;
            end
            body = {body, slave_addr_shadow};
            case (op)
                OP_WRITE_COIL: body = {body, FC_WRITE_COIL};
                OP_WRITE_REGS: body = {body, FC_WRITE_REGS};
                default:       body = {body, FC_READ_INPUT};
            endcase
            body = {body, addr[15:8]};
            body = {body, addr[7:0]};
            case (op)
                OP_WRITE_COIL: begin
                    // only bit 0 of the payload picks on or off
                    body = {body, (pay[0] ? BYTE_ONES : BYTE_ZERO)};
                    body = {body, BYTE_ZERO};
                end
                OP_WRITE_REGS: begin
                    body = {body, BYTE_ZERO};
                    body = {body, REG_COUNT};
                    body = {body, BYTE_COUNT};
                    // low word first, each word big-endian
                    body = {body, pay[15:8]};
                    body = {body, pay[7:0]};
                    body = {body, pay[31:24]};
                    body = {body, pay[23:16]};
                end
                default: begin
                    body = {body, BYTE_ZERO};
                    body = {body, REG_COUNT};
                end
            endcase
            crc = CRC_INIT;
            foreach (body[i]) begin
                crc = crc16_shift_byte(crc, body[i]);
            end
            body = {body, crc[7:0]};
            body = {body, crc[15:8]};
            foreach (body[i]) begin
                fb.data = body[i];
                fb.last = (i == body.size() - 1);
                pending_frame_bytes = {pending_frame_bytes, fb};
            end
        end
    endtask

    // Offer one command and hold it until the block takes the transaction.
    // Gaps are inserted only at burst boundaries so tvalid never drops and
    // rises within one step.
    task automatic send_command(input t_op op, input logic [15:0] addr,
                                input logic [31:0] pay);
        int gap;
        begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = sender_gaps_on ? $urandom_range(0, 7) : 0;
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {pay, addr};
            s_axis_tuser <= op;
            do begin
                @(posedge i_clk);
            end while (!(s_axis_tvalid && s_axis_tready));
            predict_request_frame(op, addr, pay);
        end
    endtask

    // Stop offering, wait out every predicted byte, then let a dropped
    // op 3 or a trailing byte clear the pipeline before the block is idle.
    task automatic drain_frames;
        begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
            while (pending_frame_bytes.size() != 0) begin
                @(posedge i_clk);
            end
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end
    endtask

    task automatic write_slave_addr(input t_byte value);
        begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_wr_data <= value;
            @(posedge i_clk);
            i_cfg_wr_en <= 1'b0;
            slave_addr_shadow = value;
        end
    endtask

    task automatic send_random_command(input int op3_pct);
        t_op          op;
        logic [31:0]  pay;
        int           pick;
        begin
            pick = $urandom_range(0, 99);
            if (pick < op3_pct) begin
                op = OP_UNUSED;
            end else if (pick < op3_pct + 30) begin
                op = OP_WRITE_COIL;
            end else if (pick < op3_pct + 65) begin
                op = OP_WRITE_REGS;
            end else begin
                op = OP_READ_INPUT;
            end
            case ($urandom_range(0, 9))
                0:       pay = 32'h0000_0000;
                1:       pay = 32'hFFFF_FFFF;
                default: pay = $urandom;
            endcase
            send_command(op, 16'($urandom), pay);
        end
    endtask

    // Frames under the reset slave address: every op, field extremes, op 3.
    task automatic test_directed_frames;
        begin
            send_command(OP_WRITE_COIL, 16'h0000, 32'h0000_0000);
            send_command(OP_WRITE_COIL, 16'hFFFF, 32'h0000_0001);
            // upper payload bits must not matter for a coil write
            send_command(OP_WRITE_COIL, 16'h1234, 32'hFFFF_FFFE);
            send_command(OP_WRITE_COIL, 16'hABCD, 32'hFFFF_FFFF);
            send_command(OP_WRITE_REGS, 16'h0000, 32'h0000_0000);
            send_command(OP_WRITE_REGS, 16'hFFFF, 32'hFFFF_FFFF);
            send_command(OP_WRITE_REGS, 16'h0102, 32'h1234_5678);
            send_command(OP_WRITE_REGS, 16'h8001, 32'h8000_0001);
            send_command(OP_READ_INPUT, 16'h0000, 32'h0000_0000);
            send_command(OP_READ_INPUT, 16'hFFFF, 32'hFFFF_FFFF);
            // payload is a don't-care for reads
            send_command(OP_READ_INPUT, 16'h4000, $urandom);
            // unused op code: taken and dropped, no bytes
            send_command(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
            send_command(OP_WRITE_REGS, 16'h5AA5, 32'hA5A5_5A5A);
            send_command(OP_UNUSED, 16'h0000, 32'h0000_0000);
            send_command(OP_UNUSED, 16'h7E7E, 32'h0F0F_F0F0);
            send_command(OP_WRITE_COIL, 16'h00FF, 32'h0000_0001);
            drain_frames();
        end
    endtask

    // Walk the slave address through its extremes and a few patterns.
    task automatic test_slave_address_sweep;
        t_byte addrs[6];
        begin
            addrs = '{8'h00, 8'hFF, 8'hA5, 8'h5A, t_byte'($urandom), SLAVE_RESET};
            foreach (addrs[i]) begin
                write_slave_addr(addrs[i]);
                send_command(OP_WRITE_COIL, 16'($urandom), $urandom);
                send_command(OP_WRITE_REGS, 16'($urandom), $urandom);
                send_command(OP_READ_INPUT, 16'($urandom), $urandom);
                drain_frames();
            end
        end
    endtask

    // Hold the receiver off for a long stretch while commands keep coming,
    // so the block fills and stalls its input; then pause until all is out.
    task automatic test_backpressure;
        begin
            hold_len_req = 300;
            hold_req_id++;
            sender_gaps_on = 1'b0;
            repeat (8) begin
                send_random_command(0);
            end
            sender_gaps_on = 1'b1;
            drain_frames();
        end
    endtask

    // Random commands with an occasional slave address change between phases.
    task automatic test_random_commands;
        int   sent_frames;
        int   pick;
        t_op  last_op;
        begin
            sent_frames = 0;
            while (sent_frames < RANDOM_COMMANDS) begin
                if (sent_frames != 0 && sent_frames % 55 == 0) begin
                    drain_frames();
                    pick = $urandom_range(0, 3);
                    write_slave_addr(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF
                                     : t_byte'($urandom));
                end
                if (sent_frames % 40 == 0) begin
                    // alternate stretches with and without sender gaps
                    sender_gaps_on = $urandom_range(0, 2) != 0;
                end
                send_random_command(10);
                last_op = s_axis_tuser;
                if (last_op != OP_UNUSED) begin
                    sent_frames++;
                end
            end
            drain_frames();
        end
    endtask

    // Receiver: random stall modes, always-ready stretches, and long holds.
    always @(posedge i_clk) begin
        if (hold_req_id != hold_ack_id) begin
            hold_cnt = hold_len_req;
            hold_ack_id = hold_req_id;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else begin
            stall_phase++;
            if (stall_phase % 64 == 0) begin
                stall_mode = $urandom_range(0, 2);
            end
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= (stall_phase % 4 != 3);
            endcase
        end
    end

    // Compare each accepted frame byte with the oldest prediction.
    always @(posedge i_clk) begin
        frame_byte_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_frame_bytes.size() == 0) begin
                $error("unexpected frame_byte %02h last_byte %0b",
                       m_axis_tdata, m_axis_tlast);
                mismatch_count++;
            end else begin
                want = pending_frame_bytes.pop_front();
                if (m_axis_tdata !== want.data) begin
                    $error("frame_byte: expected %02h, actual %02h",
                           want.data, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_byte: expected %0b, actual %0b",
                           want.last, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_frames();
        test_slave_address_sweep();
        test_backpressure();
        test_random_commands();

        drain_frames();
        if (mismatch_count == 0 && pending_frame_bytes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        #RUN_LIMIT_NS;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
